### rtl/core/battery_percent_trimmed_mean_filter_macros.svh
// Assertion macros shared by the battery percentage filter RTL
`ifndef BATTERY_PERCENT_TRIMMED_MEAN_FILTER_MACROS_SVH
`define BATTERY_PERCENT_TRIMMED_MEAN_FILTER_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define BPTM_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bptm check failed");

// Check that the consequent holds in the cycle after the antecedent
`define BPTM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bptm check failed");

`endif

### rtl/core/bptm_pkg.sv
// Shared constants for the battery percentage trimmed-mean filter
package bptm_pkg;

    localparam int unsigned WINDOW_DEF = 8;
    localparam int unsigned SAMPLE_W   = 8;
    localparam int unsigned PCT_W      = 7;
    localparam int unsigned QUO_W      = 7;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 8'd100;
    localparam logic [7:0]          TRIM_MIN   = 8'd3;
    localparam int unsigned         TRIM_DROP  = 2;
    localparam logic [PCT_W-1:0]    PCT_TOP    = 7'h7F;

endpackage

### rtl/core/bptm_ram.sv
// Generic single-write, single-read RAM with registered read data
module bptm_ram #(
    parameter int unsigned WIDTH  = 7,
    parameter int unsigned DEPTH  = 8,
    parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/bptm_div.sv
// Restoring serial divider, one quotient bit per cycle, narrow quotient
module bptm_div #(
    parameter int unsigned SUM_W = 10,
    parameter int unsigned CNT_W = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [SUM_W-1:0]           i_dividend,
    input  logic [CNT_W-1:0]           i_divisor,
    output logic                       o_done,
    output logic [bptm_pkg::QUO_W-1:0] o_quotient
);

    import bptm_pkg::*;

    localparam int unsigned DW     = SUM_W + QUO_W;
    localparam int unsigned STEP_W = $clog2(QUO_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(QUO_W - 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [DW-1:0]     r_rem;
    logic [DW-1:0]     r_dsr;
    logic [QUO_W-1:0]  r_quo;
    logic              fits;

    assign fits = (r_rem >= r_dsr);

    // Control: count quotient bits, pulse done after the last one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= r_busy && !i_start && (r_step == LAST_STEP);
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                if (r_step == LAST_STEP) begin
                    r_busy <= 1'b0;
                end else begin
                    r_step <= r_step + 1'b1;
                end
            end
        end
    end

    // Datapath: trial subtract, shift divisor right
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= DW'(i_dividend);
            r_dsr <= DW'(i_divisor) << (QUO_W - 1);
            r_quo <= '0;
        end else if (r_busy) begin
            if (fits) begin
                r_rem <= r_rem - r_dsr;
            end
            r_quo <= {r_quo[QUO_W-2:0], fits};
            r_dsr <= r_dsr >> 1;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

### rtl/core/battery_percent_trimmed_mean_filter.sv
// Each request walks the n window entries through the RAM read port, then passes a trim
// state, the serial divider and an emit state before the result loads the output register.
// A rejected sample skips the walk, trim and divider and goes straight to emit. Throughput:
// one request at a time; the input stalls until the result is in the output register.
// Reset (synchronous, active low) clears mode, fill count, pointer, held value and
// output valid; window RAM contents stay undefined until written.
module battery_percent_trimmed_mean_filter #(
    parameter int unsigned WINDOW = bptm_pkg::WINDOW_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [bptm_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                          i_charging,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [bptm_pkg::PCT_W-1:0]    o_percent,
    output logic                          o_known
);

    import bptm_pkg::*;

    `include "battery_percent_trimmed_mean_filter_macros.svh"

    localparam int unsigned CNT_W = $clog2(WINDOW + 1);
    localparam int unsigned PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int unsigned SUM_W = $clog2(WINDOW * 100 + 1);
    localparam logic [CNT_W-1:0] FILL_MAX = CNT_W'(WINDOW);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_WALK = 3'd1;
    localparam logic [2:0] S_TRIM = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    logic [2:0]       r_state;
    logic [2:0]       n_state;
    logic [CNT_W-1:0] r_fill;
    logic [PTR_W-1:0] r_ptr;
    logic [PCT_W-1:0] r_held;
    logic             r_held_valid;
    logic             r_mode_charging;
    logic             r_mode_latched;
    logic [CNT_W-1:0] r_idx;
    logic             r_rd_vld;
    logic [SUM_W-1:0] r_sum;
    logic [PCT_W-1:0] r_lo;
    logic [PCT_W-1:0] r_hi;
    logic [PCT_W-1:0] r_res_pct;
    logic             r_res_known;
    logic             r_out_valid;
    logic [PCT_W-1:0] r_out_pct;
    logic             r_out_known;

    logic             accept;
    logic             mode_clr;
    logic             reject;
    logic [CNT_W-1:0] fill_base;
    logic [PTR_W-1:0] ptr_base;
    logic             ram_we;
    logic [PCT_W-1:0] rd_data;
    logic             div_start;
    logic             div_done;
    logic [QUO_W-1:0] div_quo;
    logic [SUM_W-1:0] div_sum;
    logic [CNT_W-1:0] div_cnt;
    logic [PCT_W-1:0] cand;
    logic             out_free;
    logic             walk_end;
    logic             trim;

    assign accept    = i_valid && !o_stall;
    assign mode_clr  = r_mode_latched && (r_mode_charging != i_charging);
    assign reject    = (i_sample > SAMPLE_MAX);
    assign fill_base = mode_clr ? '0 : r_fill;
    assign ptr_base  = mode_clr ? '0 : r_ptr;
    assign ram_we    = accept && !reject;
    assign out_free  = !r_out_valid || !i_stall;
    assign walk_end  = (r_idx == r_fill) && !r_rd_vld;
    assign trim      = (8'(r_fill) >= TRIM_MIN);
    assign div_start = (r_state == S_TRIM);

    // Drop one minimum and one maximum with three or more entries
    assign div_sum = trim ? (r_sum - SUM_W'(r_lo) - SUM_W'(r_hi)) : r_sum;
    assign div_cnt = trim ? (r_fill - CNT_W'(TRIM_DROP)) : r_fill;

    // Window store
    bptm_ram #(
        .WIDTH (PCT_W),
        .DEPTH (WINDOW),
        .ADDR_W(PTR_W)
    ) u_window (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ptr_base),
        .i_wdata(i_sample[PCT_W-1:0]),
        .i_raddr(r_idx[PTR_W-1:0]),
        .o_rdata(rd_data)
    );

    // Serial divider for the mean
    bptm_div #(
        .SUM_W(SUM_W),
        .CNT_W(CNT_W)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_dividend(div_sum),
        .i_divisor (div_cnt),
        .o_done    (div_done),
        .o_quotient(div_quo)
    );

    // Clamp the mean against the held value by mode
    always_comb begin
        cand = div_quo[PCT_W-1:0];
        if (r_held_valid) begin
            if (r_mode_charging) begin
                if (cand < r_held) begin
                    cand = r_held;
                end
            end else if (cand > r_held) begin
                cand = r_held;
            end
        end
    end

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = reject ? S_EMIT : S_WALK;
                end
            end
            S_WALK: begin
                if (walk_end) begin
                    n_state = S_TRIM;
                end
            end
            S_TRIM: n_state = S_DIV;
            S_DIV: begin
                if (div_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state: mode, fill, pointer, held value, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_fill          <= '0;
            r_ptr           <= '0;
            r_held          <= '0;
            r_held_valid    <= 1'b0;
            r_mode_charging <= 1'b0;
            r_mode_latched  <= 1'b0;
            r_rd_vld        <= 1'b0;
            r_idx           <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state <= n_state;
            // Load the output register or drop it once taken
            if ((r_state == S_EMIT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_mode_charging <= i_charging;
                        r_mode_latched  <= 1'b1;
                        if (mode_clr) begin
                            r_held       <= '0;
                            r_held_valid <= 1'b0;
                        end
                        if (reject) begin
                            r_fill <= fill_base;
                            r_ptr  <= ptr_base;
                        end else begin
                            r_ptr  <= (ptr_base == PTR_LAST) ? '0 : ptr_base + 1'b1;
                            r_fill <= (fill_base == FILL_MAX) ? fill_base
                                                              : fill_base + 1'b1;
                        end
                        r_idx    <= '0;
                        r_rd_vld <= 1'b0;
                    end
                end
                S_WALK: begin
                    // Advance the read address until the fill count is reached
                    r_rd_vld <= (r_idx != r_fill);
                    if (r_idx != r_fill) begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_TRIM: begin
                end
                S_DIV: begin
                    if (div_done) begin
                        r_held       <= cand;
                        r_held_valid <= 1'b1;
                    end
                end
                S_EMIT: begin
                end
                default: begin
                end
            endcase
        end
    end

    // Datapath: accumulate sum, min, max; hold result
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_sum       <= '0;
                r_lo        <= PCT_TOP;
                r_hi        <= '0;
                r_res_pct   <= '0;
                r_res_known <= 1'b0;
            end
            S_WALK: begin
                if (r_rd_vld) begin
                    r_sum <= r_sum + SUM_W'(rd_data);
                    if (rd_data < r_lo) begin
                        r_lo <= rd_data;
                    end
                    if (rd_data > r_hi) begin
                        r_hi <= rd_data;
                    end
                end
            end
            S_TRIM: begin
            end
            S_DIV: begin
                if (div_done) begin
                    r_res_pct   <= cand;
                    r_res_known <= 1'b1;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    r_out_pct   <= r_res_pct;
                    r_out_known <= r_res_known;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_stall   = (r_state != S_IDLE);
    assign o_valid   = r_out_valid;
    assign o_percent = r_out_pct;
    assign o_known   = r_out_known;

    `BPTM_ASSERT_SAME(a_unknown_is_zero, o_valid && !o_known, o_percent == '0)
    `BPTM_ASSERT_SAME(a_fill_bounded, 1'b1, r_fill <= FILL_MAX)
    `BPTM_ASSERT_NEXT(a_busy_after_accept, accept, o_stall)
    `BPTM_ASSERT_NEXT(a_held_after_mean, (r_state == S_DIV) && div_done, r_held_valid)

endmodule

### verif/tb_top.sv
// Testbench for the battery percentage trimmed-mean filter: random and directed requests, scoreboard
module tb_top;

    localparam int unsigned WIN          = bptm_pkg::WINDOW_DEF;
    localparam int unsigned SW           = bptm_pkg::SAMPLE_W;
    localparam int unsigned PW           = bptm_pkg::PCT_W;
    localparam int unsigned CYCLE_LIMIT  = 300000;
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned RANDOM_REQS  = 650;
    localparam int unsigned MAX_REPORTS  = 10;

    typedef struct packed {
        logic [SW-1:0] sample;
        logic          charging;
    } battery_req_t;

    typedef struct packed {
        logic [PW-1:0] percent;
        logic          known;
    } level_t;

    logic          i_clk      = 1'b0;
    logic          i_rst_n    = 1'b0;
    logic          i_valid    = 1'b0;
    logic [SW-1:0] i_sample   = '0;
    logic          i_charging = 1'b0;
    logic          i_stall    = 1'b0;
    logic          o_stall;
    logic          o_valid;
    logic [PW-1:0] o_percent;
    logic          o_known;

    battery_req_t pending_reqs[$];
    level_t       expected_levels[$];
    logic         req_taken = 1'b0;
    int unsigned  mismatch_cnt = 0;
    int unsigned  cycle_cnt = 0;
    int unsigned  send_idle_pct = 32;
    int unsigned  recv_idle_pct = 75;
    logic         run_mode = 1'b1;

    // Filter state as the predictor sees it
    logic [PW-1:0] win_m[WIN];
    int unsigned   fill_m = 0;
    int unsigned   wptr_m = 0;
    logic [PW-1:0] held_m = '0;
    logic          held_valid_m = 1'b0;
    logic          mode_chg_m = 1'b0;
    logic          mode_set_m = 1'b0;

    battery_percent_trimmed_mean_filter #(
        .WINDOW(WIN)
    ) u_top (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_sample  (i_sample),
        .i_charging(i_charging),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_percent (o_percent),
        .o_known   (o_known)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Advance the filter state by one request and return the level it reports
    function automatic level_t predict_level(input battery_req_t req);
        level_t        res;
        int unsigned   total;
        int unsigned   lo;
        int unsigned   hi;
        int unsigned   n;
        int unsigned   k;
        logic [PW-1:0] cand;
        res = '0;
        // latch the mode on the first request, clear on a mode change
        if (!mode_set_m) begin
            mode_chg_m = req.charging;
            mode_set_m = 1'b1;
        end else if (mode_chg_m != req.charging) begin
            fill_m       = 0;
            wptr_m       = 0;
            held_m       = '0;
            held_valid_m = 1'b0;
            mode_chg_m   = req.charging;
        end
        if (req.sample > bptm_pkg::SAMPLE_MAX) begin
            return res;
        end
        win_m[wptr_m] = req.sample[PW-1:0];
        wptr_m = (wptr_m + 1) % WIN;
        if (fill_m < WIN) begin
            fill_m++;
        end
        // mean over the window, dropping one min and one max once three are held
        total = 0;
        lo    = win_m[0];
        hi    = lo;
        n     = fill_m;
        for (k = 0; k < n; k++) begin
            total += win_m[k];
            if (win_m[k] < lo) lo = win_m[k];
            if (win_m[k] > hi) hi = win_m[k];
        end
        if (n >= 3) begin
            total -= lo + hi;
            n     -= 2;
        end
        cand = PW'(total / n);
        // never fall while charging, never rise while discharging
        if (held_valid_m) begin
            if (mode_chg_m && cand < held_m) begin
                cand = held_m;
            end else if (!mode_chg_m && cand > held_m) begin
                cand = held_m;
            end
        end
        held_m       = cand;
        held_valid_m = 1'b1;
        res.percent  = cand;
        res.known    = 1'b1;
        return res;
    endfunction

    task automatic add_req(input logic [SW-1:0] sample, input logic charging);
        battery_req_t req;
        req.sample   = sample;
        req.charging = charging;
        pending_reqs.push_back(req);
    endtask

    // Mostly steady runs in one mode around a drifting level; the rest rejects and noise
    task automatic add_random_reqs(input int unsigned count);
        int unsigned made;
        int unsigned pick;
        int unsigned run_len;
        int unsigned k;
        int          level;
        int          s;
        made = 0;
        while (made < count) begin
            pick = $urandom_range(99);
            if (pick < 80) begin
                if ($urandom_range(9) < 2) run_mode = ~run_mode;
                run_len = $urandom_range(14, 1);
                level   = $urandom_range(100);
                for (k = 0; k < run_len; k++) begin
                    s = level + int'($urandom_range(12)) - 6;
                    if (s < 0) s = 0;
                    if (s > 100) s = 100;
                    if ($urandom_range(19) == 0) s = $urandom_range(1) ? 100 : 0;
                    if ($urandom_range(24) == 0) s = $urandom_range(255, 101);
                    add_req(SW'(s), run_mode);
                    if (run_mode && level < 100) begin
                        level++;
                    end else if (!run_mode && level > 0) begin
                        level--;
                    end
                end
                made += run_len;
            end else if (pick < 90) begin
                add_req(SW'($urandom_range(255, 101)),
                        ($urandom_range(9) < 8) ? run_mode : ~run_mode);
                made++;
            end else begin
                add_req(SW'($urandom_range(255)), 1'($urandom_range(1)));
                made++;
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || expected_levels.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Drive requests and the result stall on the falling edge
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || req_taken) begin
                if (i_valid) begin
                    void'(pending_reqs.pop_front());
                end
                if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_valid    <= 1'b1;
                    i_sample   <= pending_reqs[0].sample;
                    i_charging <= pending_reqs[0].charging;
                end else begin
                    i_valid <= 1'b0;
                end
            end
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Check results and predict accepted requests on the rising edge
    always @(posedge i_clk) begin
        battery_req_t req;
        level_t       want;
        if (!i_rst_n) begin
            req_taken <= 1'b0;
        end else begin
            req_taken <= i_valid && !o_stall;
            if (o_valid && !i_stall) begin
                if (expected_levels.size() == 0) begin
                    if (mismatch_cnt < MAX_REPORTS) begin
                        $display("unexpected result: percent=%0d known=%0b", o_percent, o_known);
                    end
                    mismatch_cnt++;
                end else begin
                    want = expected_levels.pop_front();
                    if (o_percent !== want.percent || o_known !== want.known) begin
                        if (mismatch_cnt < MAX_REPORTS) begin
                            $display("mismatch: percent exp=%0d got=%0d, known exp=%0b got=%0b",
                                     want.percent, o_percent, want.known, o_known);
                        end
                        mismatch_cnt++;
                    end
                end
            end
            if (i_valid && !o_stall) begin
                req.sample   = i_sample;
                req.charging = i_charging;
                expected_levels.push_back(predict_level(req));
            end
        end
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        foreach (win_m[i]) win_m[i] = '0;

        // first request rejected, then charging with the clamp holding the level up
        add_req(8'd255, 1'b1);
        add_req(8'd50, 1'b1);
        add_req(8'd101, 1'b1);
        add_req(8'd100, 1'b1);
        add_req(8'd0, 1'b1);
        // mode change with an accepted sample, then with a rejected one
        add_req(8'd0, 1'b0);
        add_req(8'd200, 1'b1);
        add_req(8'd100, 1'b1);
        // discharging: fill past the window size so the ring wraps
        add_req(8'd0, 1'b0);
        add_req(8'd100, 1'b0);
        add_req(8'd90, 1'b0);
        add_req(8'd80, 1'b0);
        add_req(8'd101, 1'b0);
        add_req(8'd70, 1'b0);
        add_req(8'd60, 1'b0);
        add_req(8'd100, 1'b0);
        add_req(8'd40, 1'b0);
        add_req(8'd30, 1'b0);
        add_req(8'd0, 1'b0);
        add_req(8'd20, 1'b0);
        add_req(8'd100, 1'b0);
        add_req(8'd255, 1'b0);
        add_random_reqs(RANDOM_REQS / 3);

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        wait_drained();

        // swap the idle pressure between sender and receiver
        send_idle_pct = 75;
        recv_idle_pct = 32;
        add_random_reqs(RANDOM_REQS / 3);
        wait_drained();

        // run flat out
        send_idle_pct = 0;
        recv_idle_pct = 0;
        add_random_reqs(RANDOM_REQS - 2 * (RANDOM_REQS / 3));
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0 && expected_levels.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/bptm_pkg.sv
rtl/core/bptm_ram.sv
rtl/core/bptm_div.sv
rtl/core/battery_percent_trimmed_mean_filter.sv
verif/tb_top.sv
